/* rtl/cr2_pkg.sv */
// Package for the 2x2 Cramer's-rule solver.
// Holds the status codes, the stage word types and the pipeline sizes.
// Depends on nothing.
`timescale 1ns / 1ps

package cr2_pkg;

  localparam int unsigned QBITS = 48;

  typedef enum logic [1:0] {
    ST_UNIQUE   = 2'd0,
    ST_NONE     = 2'd1,
    ST_INFINITE = 2'd2
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [32:0] det;
    logic [32:0] nx;
    logic [32:0] ny;
  } front_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [QBITS-1:0] work;
  } lane_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] den;
    lane_t       lx;
    lane_t       ly;
  } cell_t;

endpackage

/* rtl/cr2_front.sv */
// Front end of the solver: six products, then determinant and numerators.
// Two register stages. Depends on cr2_pkg.
`timescale 1ns / 1ps

module cr2_front
  import cr2_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic signed [15:0] coef_a1,
  input  logic signed [15:0] coef_b1,
  input  logic signed [15:0] rhs_c1,
  input  logic signed [15:0] coef_a2,
  input  logic signed [15:0] coef_b2,
  input  logic signed [15:0] rhs_c2,
  output front_t             word
);

  logic               p_valid;
  logic signed [31:0] p_a1b2, p_a2b1, p_c1b2, p_c2b1, p_a1c2, p_a2c1;
  logic               s_valid;
  logic [32:0]        s_det, s_nx, s_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      p_valid <= load;
      s_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_a1b2 <= coef_a1 * coef_b2;
    p_a2b1 <= coef_a2 * coef_b1;
    p_c1b2 <= rhs_c1 * coef_b2;
    p_c2b1 <= rhs_c2 * coef_b1;
    p_a1c2 <= coef_a1 * rhs_c2;
    p_a2c1 <= coef_a2 * rhs_c1;
    s_det  <= {p_a1b2[31], p_a1b2} - {p_a2b1[31], p_a2b1};
    s_nx   <= {p_c1b2[31], p_c1b2} - {p_c2b1[31], p_c2b1};
    s_ny   <= {p_a1c2[31], p_a1c2} - {p_a2c1[31], p_a2c1};
  end

  assign word.valid = s_valid;
  assign word.det   = s_det;
  assign word.nx    = s_nx;
  assign word.ny    = s_ny;

endmodule

/* rtl/cr2_div_cell.sv */
// One cell of the divider chain: one restoring quotient bit for each of the
// x and y lanes, registered. Depends on cr2_pkg.
`timescale 1ns / 1ps

module cr2_div_cell
  import cr2_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cell_t din,
  output cell_t dout
);

  function automatic lane_t div_step(lane_t l, logic [31:0] den);
    logic [32:0] t;
    logic [32:0] diff;
    lane_t       r;
    t    = {l.rem, l.work[QBITS-1]};
    diff = t - {1'b0, den};
    if (!diff[32]) begin
      r.rem  = diff[31:0];
      r.work = {l.work[QBITS-2:0], 1'b1};
    end else begin
      r.rem  = t[31:0];
      r.work = {l.work[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

  logic  valid;
  cell_t pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    pay.valid  <= 1'b0;
    pay.status <= din.status;
    pay.neg_x  <= din.neg_x;
    pay.neg_y  <= din.neg_y;
    pay.den    <= din.den;
    pay.lx     <= div_step(din.lx, din.den);
    pay.ly     <= div_step(din.ly, din.den);
  end

  always_comb begin
    dout       = pay;
    dout.valid = valid;
  end

endmodule

/* rtl/cramer_2x2_linear_solver_core.sv */
// 2x2 linear system solver by Cramer's rule, Q8.8 in, Q16.16 out.
// Pipeline: two front stages,
// 48 divider cells (one quotient bit each) and an output register.
// Throughput: one word per cycle; busy is always low.
// The receiver cannot stall; each result is shown for one cycle under done.
// Reset (synchronous, rst high) clears every valid flag in the pipeline.
`timescale 1ns / 1ps

module cramer_2x2_linear_solver_core
  import cr2_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] coef_a1,
  input  logic signed [15:0] coef_b1,
  input  logic signed [15:0] rhs_c1,
  input  logic signed [15:0] coef_a2,
  input  logic signed [15:0] coef_b2,
  input  logic signed [15:0] rhs_c2,
  output logic               done,
  output logic signed [31:0] sol_x,
  output logic signed [31:0] sol_y,
  output logic [1:0]         status,
  output logic               saturated
);

  front_t      fw;
  cell_t       chain [0:QBITS];
  logic [32:0] abs_det, abs_nx, abs_ny;
  logic [31:0] qx_next, qy_next;
  logic        satx, saty;

  assign busy = 1'b0;

  cr2_front u_front (
    .clk(clk), .rst(rst), .load(start && !busy),
    .coef_a1(coef_a1), .coef_b1(coef_b1), .rhs_c1(rhs_c1),
    .coef_a2(coef_a2), .coef_b2(coef_b2), .rhs_c2(rhs_c2),
    .word(fw)
  );

  always_comb begin
    abs_det = fw.det[32] ? (33'd0 - fw.det) : fw.det;
    abs_nx  = fw.nx[32]  ? (33'd0 - fw.nx)  : fw.nx;
    abs_ny  = fw.ny[32]  ? (33'd0 - fw.ny)  : fw.ny;
    chain[0].valid   = fw.valid;
    chain[0].neg_x   = fw.nx[32] ^ fw.det[32];
    chain[0].neg_y   = fw.ny[32] ^ fw.det[32];
    chain[0].den     = abs_det[31:0];
    chain[0].lx.rem  = 32'd0;
    chain[0].lx.work = {abs_nx[31:0], 16'd0};
    chain[0].ly.rem  = 32'd0;
    chain[0].ly.work = {abs_ny[31:0], 16'd0};
    if (fw.det != 33'd0) begin
      chain[0].status = ST_UNIQUE;
    end else if (fw.nx != 33'd0 || fw.ny != 33'd0) begin
      chain[0].status = ST_NONE;
    end else begin
      chain[0].status = ST_INFINITE;
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    cr2_div_cell u_cell (.clk(clk), .rst(rst), .din(chain[i]), .dout(chain[i+1]));
  end

  function automatic logic [32:0] clip(logic [QBITS-1:0] q, logic neg);
    logic [32:0] r;
    if (neg) begin
      if (q > QBITS'(33'h080000000)) begin
        r = {1'b1, 32'h80000000};
      end else begin
        r = {1'b0, 32'd0 - q[31:0]};
      end
    end else begin
      if (q > QBITS'(33'h07FFFFFFF)) begin
        r = {1'b1, 32'h7FFFFFFF};
      end else begin
        r = {1'b0, q[31:0]};
      end
    end
    return r;
  endfunction

  always_comb begin
    {satx, qx_next} = clip(chain[QBITS].lx.work, chain[QBITS].neg_x);
    {saty, qy_next} = clip(chain[QBITS].ly.work, chain[QBITS].neg_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[QBITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    status <= chain[QBITS].status;
    if (chain[QBITS].status == ST_UNIQUE) begin
      sol_x     <= qx_next;
      sol_y     <= qy_next;
      saturated <= satx | saty;
    end else begin
      sol_x     <= 32'sd0;
      sol_y     <= 32'sd0;
      saturated <= 1'b0;
    end
  end

  a_front_load: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 fw.valid) else $error("front stage lost a word");
  a_last_done: assert property (@(posedge clk)
    !rst && chain[QBITS].valid |=> done) else $error("done strobe missing");
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_UNIQUE |-> sol_x == 0 && sol_y == 0 && !saturated)
    else $error("fields not cleared for a singular system");
  a_sat_unique: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> status == ST_UNIQUE)
    else $error("saturation flagged without a unique solution");

endmodule
